// ===== sv/key_state_map_with_history_fifo_core_defines.svh =====
// Assertion macros shared by the key state map core.
`ifndef KEY_STATE_MAP_WITH_HISTORY_FIFO_CORE_DEFINES_SVH
`define KEY_STATE_MAP_WITH_HISTORY_FIFO_CORE_DEFINES_SVH

// Plain property, checked at every clock edge out of reset
`define KSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication, checked out of reset
`define KSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ksm_pkg.sv =====
// Package: types and constants of the key state map core.
package ksm_pkg;

  localparam int unsigned SCANCODE_BITS = 16;
  localparam int unsigned KEY_COUNT     = 128;
  localparam int unsigned KEY_IDX_W     = $clog2(KEY_COUNT);
  localparam int unsigned HISTORY_DEPTH = 256;
  localparam int unsigned REQ_W         = 3;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [CFG_DATA_W-1:0] RELEASE_MASK_RST  = 16'h0080;
  localparam logic [CFG_DATA_W-1:0] EXTENDED_MASK_RST = 16'h0100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELEASE_MASK  = 1'b0,
    CFG_EXTENDED_MASK = 1'b1
  } cfg_idx_e;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_EVENT = 3'd0,
    REQ_TEST  = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_POP   = 3'd3,
    REQ_CLEAR = 3'd4
  } req_e;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

// ===== sv/ksm_req_if.sv =====
// Request channel interface: valid/ready plus request payload.
interface ksm_req_if;
  logic                               valid;
  logic                               ready;
  logic [ksm_pkg::REQ_W-1:0]          req_type;
  logic [ksm_pkg::SCANCODE_BITS-1:0]  scancode;

  modport source (output valid, output req_type, output scancode, input ready);
  modport sink   (input valid, input req_type, input scancode, output ready);
endinterface

// ===== sv/ksm_rsp_if.sv =====
// Response channel interface: valid/ready plus result payload.
interface ksm_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               key_down;
  logic [ksm_pkg::SCANCODE_BITS-1:0]  key_out;
  logic                               history_nonempty;
  logic                               push_dropped;

  modport source (output valid, output key_down, output key_out,
                  output history_nonempty, output push_dropped, input ready);
  modport sink   (input valid, input key_down, input key_out,
                  input history_nonempty, input push_dropped, output ready);
endinterface

// ===== sv/key_state_map_with_history_fifo_core.sv =====
// Top level: key-down map and scancode history ring with request/response channels.
//
// Usage: requests arrive on req_i (valid/ready, req_type + scancode); each
// request gives exactly one response on rsp_o (valid/ready). Kinds: key event,
// test key, peek history, pop history, clear history.
// A response becomes valid when the execute state loads the output register.
// A request is accepted only in the idle state, so not before the previous one
// has executed. On the accept the key map RAM and the history RAM are read
// (registered read port); the execute state modifies and writes back both.
// A new request is taken while an earlier response still waits in the output
// register; if the receiver stalls, the block holds in its execute cycle with
// the read data kept until the output register frees up.
// Reset: key map reads as all zero (per-key valid bits cleared at once), the
// history ring is empty, masks return to 0x0080 and 0x0100. No clearing pass.
// Configuration: cfg_we_i/cfg_idx_i/cfg_wdata_i write a mask at the clock edge; the
// user must write only while no request is in flight, the block does not enforce it.
`include "key_state_map_with_history_fifo_core_defines.svh"

module key_state_map_with_history_fifo_core #(
  parameter int unsigned HISTORY_DEPTH = ksm_pkg::HISTORY_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ksm_req_if.sink                          req_i,
  ksm_rsp_if.source                        rsp_o,
  input  logic                             cfg_we_i,
  input  logic [ksm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ksm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned PtrW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CodeW = ksm_pkg::SCANCODE_BITS;
  localparam int unsigned KeyW = ksm_pkg::KEY_IDX_W;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(HISTORY_DEPTH - 1);

  ksm_pkg::state_e             state_q, state_d;
  ksm_pkg::req_e               req_q;
  logic [CodeW-1:0]            code_q;
  logic [PtrW-1:0]             head_q, head_d, tail_q, tail_d;
  logic [CodeW-1:0]            rel_mask_q, ext_mask_q;
  logic [ksm_pkg::KEY_COUNT-1:0] key_valid_q;

  logic                        out_valid_q, out_kd_q, out_ne_q, out_drop_q;
  logic [CodeW-1:0]            out_ko_q;

  logic                        in_fire, exec_fire;
  logic                        nonempty, full;
  logic [PtrW-1:0]             next_tail, next_head;
  logic [KeyW-1:0]             key_idx;

  logic                        key_we, key_wdata, key_rdata;
  logic                        hist_we;
  logic [CodeW-1:0]            hist_rdata;
  logic                        kd_d, ne_d, drop_d;
  logic [CodeW-1:0]            ko_d;

  assign in_fire     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ksm_pkg::S_IDLE);
  assign exec_fire   = (state_q == ksm_pkg::S_EXEC) && (!out_valid_q || rsp_o.ready);

  // ring pointer arithmetic
  assign nonempty  = (head_q != tail_q);
  assign next_tail = (tail_q == PtrLast) ? '0 : tail_q + PtrW'(1);
  assign next_head = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
  assign full      = (next_tail == head_q);
  assign key_idx   = code_q[KeyW-1:0];

  // key-down map storage
  ksm_ram #(.WIDTH(1), .DEPTH(ksm_pkg::KEY_COUNT)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_idx),
    .wdata_i (key_wdata),
    .re_i    (in_fire),
    .raddr_i (req_i.scancode[KeyW-1:0]),
    .rdata_o (key_rdata)
  );

  // history ring storage
  ksm_ram #(.WIDTH(CodeW), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (tail_q),
    .wdata_i (code_q & ~ext_mask_q),
    .re_i    (in_fire),
    .raddr_i (head_q),
    .rdata_o (hist_rdata)
  );

  // sequencer: next state, write-back and result
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    key_we    = 1'b0;
    key_wdata = ((code_q & rel_mask_q) == '0);
    hist_we   = 1'b0;
    kd_d      = 1'b0;
    ko_d      = '0;
    ne_d      = nonempty;
    drop_d    = 1'b0;
    case (state_q)
      ksm_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = ksm_pkg::S_EXEC;
        end
      end
      ksm_pkg::S_EXEC: begin
        if (exec_fire) begin
          state_d = ksm_pkg::S_IDLE;
          case (req_q)
            ksm_pkg::REQ_EVENT: begin
              if (code_q != '0) begin
                key_we = 1'b1;
                drop_d = full;
                if (!full) begin
                  hist_we = 1'b1;
                  tail_d  = next_tail;
                end
              end
            end
            ksm_pkg::REQ_TEST: begin
              kd_d = key_valid_q[key_idx] & key_rdata;
            end
            ksm_pkg::REQ_PEEK: begin
              if (nonempty) begin
                ko_d = hist_rdata;
              end
            end
            ksm_pkg::REQ_POP: begin
              if (nonempty) begin
                ko_d   = hist_rdata;
                head_d = next_head;
              end
            end
            ksm_pkg::REQ_CLEAR: begin
              tail_d = head_q;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ksm_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ksm_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      key_valid_q <= '0;
      out_valid_q <= 1'b0;
      rel_mask_q  <= ksm_pkg::RELEASE_MASK_RST;
      ext_mask_q  <= ksm_pkg::EXTENDED_MASK_RST;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      if (key_we) begin
        key_valid_q[key_idx] <= 1'b1;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ksm_pkg::CFG_RELEASE_MASK:  rel_mask_q <= cfg_wdata_i;
          ksm_pkg::CFG_EXTENDED_MASK: ext_mask_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers: captured request and output result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q  <= ksm_pkg::req_e'(req_i.req_type);
      code_q <= req_i.scancode;
    end
    if (exec_fire) begin
      out_kd_q   <= kd_d;
      out_ko_q   <= ko_d;
      out_ne_q   <= ne_d;
      out_drop_q <= drop_d;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.key_down         = out_kd_q;
  assign rsp_o.key_out          = out_ko_q;
  assign rsp_o.history_nonempty = out_ne_q;
  assign rsp_o.push_dropped     = out_drop_q;

  // checks
  `KSM_ASSERT_NEXT(a_accept_to_exec, in_fire, state_q == ksm_pkg::S_EXEC,
    "accept did not enter execute")
  `KSM_ASSERT_NEXT(a_exec_loads_out, exec_fire, out_valid_q,
    "execute did not load output register")
  `KSM_ASSERT_NEXT(a_kd_only_test, exec_fire && (req_q != ksm_pkg::REQ_TEST), !out_kd_q,
    "key_down set on non-test")
  `KSM_ASSERT_NEXT(a_pop_empty_head,
    exec_fire && (req_q == ksm_pkg::REQ_POP) && !nonempty, $stable(head_q),
    "pop on empty moved head")
  `KSM_ASSERT(a_no_write_idle, !(hist_we || key_we) || (state_q == ksm_pkg::S_EXEC),
    "RAM write outside execute")

endmodule

// ===== sv/ksm_ram.sv =====
// Generic single-clock RAM: one write port, one registered read port.
module ksm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
